/* sv/rrtt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the round robin task table.
// Depends on nothing; used by every other file of the block.
package rrtt_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int TASK_W    = 32;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SWITCH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

endpackage
`default_nettype wire

/* sv/rrtt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on rrtt_pkg for its default parameters.
module rrtt_ram #(
  parameter int WIDTH = rrtt_pkg::TASK_W,
  parameter int DEPTH = rrtt_pkg::SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

/* sv/round_robin_task_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Round robin task table: top level with the slot-scan sequencer.
// Uses rrtt_pkg and rrtt_ram for the task identifier storage.
// Add or remove scan all slots in S_FIND, then S_DECIDE; a removal moving the current
// task, or a switch with a task present, searches in S_NEXT; all end in S_RD and S_LOAD,
// which full, refused or unused codes enter directly. The scan reads one slot per cycle
// through the single read port of the identifier RAM. A new transaction is accepted the
// cycle after a result is loaded; a waiting result holds only the next load.
// Synchronous reset clears state, count, cur, present, out_valid and used bits; not RAM.
module round_robin_task_table #(
  parameter int SLOTS = rrtt_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_task_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_current_task,
  output logic             out_current_valid
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_DECIDE, S_NEXT, S_RD, S_LOAD
  } state_t;

  state_t                  state_r;
  logic [SLOTS-1:0]        used_r;
  logic [CW-1:0]           count_r;
  logic [IW-1:0]           cur_r;
  logic                    present_r;
  logic                    out_valid_r;
  logic [1:0]              kind_r;
  logic [31:0]             id_r;
  logic [1:0]              status_r;
  logic [CW-1:0]           cnt_r;
  logic [IW-1:0]           idx_r;
  logic                    pend_r;
  logic [IW-1:0]           cmp_idx_r;
  logic                    found_r;
  logic [IW-1:0]           found_idx_r;
  logic                    free_found_r;
  logic [IW-1:0]           free_idx_r;
  logic [1:0]              out_status_r;
  logic [31:0]             out_task_r;
  logic                    out_cv_r;

  logic [IW-1:0]           cnt_idx;
  logic                    cnt_done;
  logic                    ram_we;
  logic [IW-1:0]           ram_raddr;
  logic [31:0]             ram_rdata;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    logic [IW-1:0] r;
    if (v == IW'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = v + 1'b1;
    end
    return r;
  endfunction

  assign cnt_idx   = cnt_r[IW-1:0];
  assign cnt_done  = (cnt_r == CW'(SLOTS));
  assign ram_we    = (state_r == S_DECIDE) && (kind_r == rrtt_pkg::KIND_ADD) && !found_r;
  assign ram_raddr = ((state_r == S_RD) || (state_r == S_LOAD)) ? cur_r : cnt_idx;

  rrtt_ram #(
    .WIDTH(32),
    .DEPTH(SLOTS)
  ) u_task_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx_r),
    .wdata(id_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      cur_r       <= '0;
      present_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r       <= in_kind;
            id_r         <= in_task_id;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            pend_r       <= 1'b0;
            case (in_kind)
              rrtt_pkg::KIND_ADD: begin
                cnt_r <= '0;
                if (count_r == CW'(SLOTS)) begin
                  status_r <= rrtt_pkg::ST_FULL;
                  state_r  <= S_RD;
                end else begin
                  status_r <= rrtt_pkg::ST_OK;
                  state_r  <= S_FIND;
                end
              end
              rrtt_pkg::KIND_REMOVE: begin
                cnt_r <= '0;
                if (count_r < CW'(2)) begin
                  status_r <= rrtt_pkg::ST_REFUSED;
                  state_r  <= S_RD;
                end else begin
                  status_r <= rrtt_pkg::ST_OK;
                  state_r  <= S_FIND;
                end
              end
              rrtt_pkg::KIND_SWITCH: begin
                status_r <= rrtt_pkg::ST_OK;
                idx_r    <= wrap_inc(cur_r);
                cnt_r    <= CW'(1);
                if (present_r) begin
                  state_r <= S_NEXT;
                end else begin
                  state_r <= S_RD;
                end
              end
              default: begin
                status_r <= rrtt_pkg::ST_OK;
                cnt_r    <= '0;
                state_r  <= S_RD;
              end
            endcase
          end
        end
        S_FIND: begin
          pend_r    <= !cnt_done;
          cmp_idx_r <= cnt_idx;
          if (pend_r && used_r[cmp_idx_r] && (ram_rdata == id_r) && !found_r) begin
            found_r     <= 1'b1;
            found_idx_r <= cmp_idx_r;
          end
          if (!cnt_done && !used_r[cnt_idx] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= cnt_idx;
          end
          if (cnt_done) begin
            state_r <= S_DECIDE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DECIDE: begin
          if (kind_r == rrtt_pkg::KIND_ADD) begin
            state_r <= S_RD;
            if (found_r) begin
              status_r <= rrtt_pkg::ST_DUP;
            end else begin
              used_r[free_idx_r] <= 1'b1;
              count_r            <= count_r + 1'b1;
              if (!present_r) begin
                present_r <= 1'b1;
                cur_r     <= free_idx_r;
              end
            end
          end else if (found_r) begin
            used_r[found_idx_r] <= 1'b0;
            count_r             <= count_r - 1'b1;
            if (present_r && (cur_r == found_idx_r)) begin
              idx_r   <= wrap_inc(found_idx_r);
              cnt_r   <= CW'(1);
              state_r <= S_NEXT;
            end else begin
              state_r <= S_RD;
            end
          end else begin
            state_r <= S_RD;
          end
        end
        S_NEXT: begin
          if (used_r[idx_r]) begin
            cur_r   <= idx_r;
            state_r <= S_RD;
          end else if (cnt_done) begin
            present_r <= 1'b0;
            cur_r     <= '0;
            state_r   <= S_RD;
          end else begin
            idx_r <= wrap_inc(idx_r);
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_RD: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (!out_valid_r || out_ready) begin
            out_status_r <= status_r;
            out_task_r   <= present_r ? ram_rdata : 32'd0;
            out_cv_r     <= present_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid_r && out_ready && (state_r != S_LOAD)) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_current_task  = out_task_r;
  assign out_current_valid = out_cv_r;

endmodule
`default_nettype wire
